/* src/cat_pkg.sv */
// ----------------------------------------------------------------------------
// cat_pkg: shared types for the compacting array table
// Request and response payloads, action codes and status codes.
// ----------------------------------------------------------------------------
package cat_pkg;

	localparam logic [2:0] ACT_PUSH   = 3'd0;
	localparam logic [2:0] ACT_FIND   = 3'd1;
	localparam logic [2:0] ACT_DELETE = 3'd2;
	localparam logic [2:0] ACT_CLEAR  = 3'd3;
	localparam logic [2:0] ACT_READ   = 3'd4;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef struct packed {
		logic [2:0]  action;
		logic [31:0] value;
		logic [7:0]  first_index;
		logic [7:0]  last_index;
	} cat_req_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  found_index;
		logic [31:0] read_value;
		logic [8:0]  fill_count;
	} cat_rsp_t;

endpackage

/* src/cat_ram.sv */
// ----------------------------------------------------------------------------
// cat_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cat_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/compacting_array_table_top.sv */
// ----------------------------------------------------------------------------
// compacting_array_table_top: packed table with fill count
// Push, find, delete range, clear and read on a table held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
//   A request transfers on req when start is high and busy is low. Each
//   request gives exactly one response on rsp, marked by a one-cycle done
//   strobe; the receiver has no way to stall it.
//   Push, clear, unused codes and rejected requests respond straight from
//   the idle state. Read responds from S_READ once the RAM data is back.
//   Find compares entries in S_FIND, up to the fill count; on an empty
//   table it responds from idle. Delete moves the entries above the range
//   down in S_SHIFT; none are moved when the range ends the table, and
//   then it responds straight from idle.
//   Find compares one entry per cycle and delete moves one entry per cycle,
//   both bound by the single RAM read port. busy is low again in the cycle
//   that shows done, so a new request can transfer while the response is out.
//   Reset clears the fill count and the controller; the RAM keeps its
//   contents and needs no clearing pass, since only entries below the fill
//   count are ever read. Clear only zeroes the fill count.
// ----------------------------------------------------------------------------
module compacting_array_table_top import cat_pkg::*; #(
	parameter int DEPTH = 256,
	parameter int ELEMENT_WIDTH = 32
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  cat_req_t req,
	output logic     done,
	output cat_rsp_t rsp
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = (CW > 8) ? CW : 8;
	localparam int EW = ELEMENT_WIDTH;
	localparam int VW = (EW > 32) ? EW : 32;

	typedef enum logic [1:0] {S_IDLE, S_READ, S_FIND, S_SHIFT} state_t;

	state_t          state_q;
	logic [CW-1:0]   count_q;
	logic [CW-1:0]   idx_q;
	logic [CW-1:0]   span_q;
	logic [EW-1:0]   val_q;
	logic            done_q;
	cat_rsp_t        rsp_q;

	logic            accept;
	logic [XW-1:0]   first_x;
	logic [XW-1:0]   last_x;
	logic [XW-1:0]   count_x;
	logic [XW-1:0]   span_x;
	logic [XW-1:0]   next_x;
	logic [VW-1:0]   value_w;
	logic [EW-1:0]   val_in;
	logic            full;
	logic            rd_bad;
	logic            del_bad;
	logic [CW-1:0]   idx_inc;
	logic [CW-1:0]   shift_dst;
	logic [EW+31:0]  rd_ext;

	logic            ram_we;
	logic [AW-1:0]   ram_waddr;
	logic [EW-1:0]   ram_wdata;
	logic [AW-1:0]   ram_raddr;
	logic [EW-1:0]   ram_rdata;

	function automatic logic [8:0] fill_of(input logic [CW-1:0] c);
		logic [CW+8:0] e;
		e = {9'b0, c};
		return e[8:0];
	endfunction

	function automatic logic [7:0] index_of(input logic [CW-1:0] c);
		logic [CW+7:0] e;
		e = {8'b0, c};
		return e[7:0];
	endfunction

	assign accept    = start && !busy;
	assign first_x   = XW'(req.first_index);
	assign last_x    = XW'(req.last_index);
	assign count_x   = XW'(count_q);
	assign span_x    = last_x - first_x + XW'(1);
	assign next_x    = last_x + XW'(1);
	assign value_w   = VW'(req.value);
	assign val_in    = value_w[EW-1:0];
	assign full      = (count_q == CW'(DEPTH));
	assign rd_bad    = (first_x >= count_x);
	assign del_bad   = (first_x > last_x) || (last_x >= count_x);
	assign idx_inc   = idx_q + CW'(1);
	assign shift_dst = idx_q - span_q;
	assign rd_ext    = {32'b0, ram_rdata};

	always_comb begin
		ram_raddr = idx_inc[AW-1:0];
		if (state_q == S_IDLE) begin
			case (req.action)
				ACT_READ:   ram_raddr = first_x[AW-1:0];
				ACT_FIND:   ram_raddr = '0;
				ACT_DELETE: ram_raddr = next_x[AW-1:0];
				default:    ram_raddr = idx_inc[AW-1:0];
			endcase
		end
	end

	always_comb begin
		if (state_q == S_SHIFT) begin
			ram_we    = 1'b1;
			ram_waddr = shift_dst[AW-1:0];
			ram_wdata = ram_rdata;
		end else begin
			ram_we    = accept && (req.action == ACT_PUSH) && !full;
			ram_waddr = count_q[AW-1:0];
			ram_wdata = val_in;
		end
	end

	cat_ram #(
		.WIDTH(EW),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						rsp_q.status      <= ST_OK;
						rsp_q.found_index <= '0;
						rsp_q.read_value  <= '0;
						rsp_q.fill_count  <= fill_of(count_q);
						unique case (req.action)
							ACT_PUSH: begin
								done_q <= 1'b1;
								if (full) begin
									rsp_q.status <= ST_FULL;
								end else begin
									count_q          <= count_q + CW'(1);
									rsp_q.fill_count <= fill_of(count_q + CW'(1));
								end
							end
							ACT_FIND: begin
								val_q <= val_in;
								idx_q <= '0;
								if (count_q == '0) begin
									rsp_q.status <= ST_NOT_FOUND;
									done_q       <= 1'b1;
								end else begin
									state_q <= S_FIND;
								end
							end
							ACT_DELETE: begin
								span_q <= span_x[CW-1:0];
								idx_q  <= next_x[CW-1:0];
								if (del_bad) begin
									rsp_q.status <= ST_BAD_INDEX;
									done_q       <= 1'b1;
								end else if (next_x >= count_x) begin
									count_q          <= count_q - span_x[CW-1:0];
									rsp_q.fill_count <= fill_of(count_q - span_x[CW-1:0]);
									done_q           <= 1'b1;
								end else begin
									state_q <= S_SHIFT;
								end
							end
							ACT_CLEAR: begin
								count_q          <= '0;
								rsp_q.fill_count <= '0;
								done_q           <= 1'b1;
							end
							ACT_READ: begin
								if (rd_bad) begin
									rsp_q.status <= ST_BAD_INDEX;
									done_q       <= 1'b1;
								end else begin
									state_q <= S_READ;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_READ: begin
					rsp_q.read_value <= rd_ext[31:0];
					done_q           <= 1'b1;
					state_q          <= S_IDLE;
				end
				S_FIND: begin
					if (ram_rdata == val_q) begin
						rsp_q.found_index <= index_of(idx_q);
						done_q            <= 1'b1;
						state_q           <= S_IDLE;
					end else if (idx_inc == count_q) begin
						rsp_q.status <= ST_NOT_FOUND;
						done_q       <= 1'b1;
						state_q      <= S_IDLE;
					end else begin
						idx_q <= idx_inc;
					end
				end
				S_SHIFT: begin
					if (idx_inc == count_q) begin
						count_q          <= count_q - span_q;
						rsp_q.fill_count <= fill_of(count_q - span_q);
						done_q           <= 1'b1;
						state_q          <= S_IDLE;
					end else begin
						idx_q <= idx_inc;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

/* src/cat_chk.sv */
// ----------------------------------------------------------------------------
// cat_chk: port-level checks for the compacting array table
// Response timing and response field consistency, bound to the top level.
// ----------------------------------------------------------------------------
module cat_chk import cat_pkg::*; #(
	parameter int DEPTH = 256
) (
	input logic     clk,
	input logic     arst_n,
	input logic     start,
	input logic     busy,
	input cat_req_t req,
	input logic     done,
	input cat_rsp_t rsp
);

	localparam logic [8:0] FILL_FULL = 9'(DEPTH);

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("response shown while busy");

	a_push_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.action == ACT_PUSH |=> done)
		else $error("push did not respond in one cycle");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && req.action == ACT_CLEAR |=>
			done && rsp.fill_count == '0 && rsp.status == ST_OK)
		else $error("clear did not empty the table");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_FULL |-> rsp.fill_count == FILL_FULL)
		else $error("full reported below capacity");

	a_not_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.status == ST_NOT_FOUND |->
			rsp.found_index == '0 && rsp.read_value == '0)
		else $error("not-found response carries data");

endmodule

bind compacting_array_table_top cat_chk #(.DEPTH(DEPTH)) u_cat_chk (.*);

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for compacting_array_table_top
// Drives push, find, delete range, clear, read and spare action codes
// through the start/busy handshake and checks every response against a
// shadow copy of the table kept in the testbench. The sender works in
// bursts with random gaps.
// ----------------------------------------------------------------------------
module tb;
	import cat_pkg::*;

	localparam int DEPTH = 256;
	localparam int RANDOM_ITEMS = 120;
	localparam int STALL_LIMIT = 4000;
	localparam logic [2:0] ACT_LAST = ACT_READ;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	logic     busy;
	cat_req_t req = '0;
	logic     done;
	cat_rsp_t rsp;

	logic [31:0] shadow_entries [DEPTH];
	int          shadow_fill = 0;
	cat_rsp_t    pending_rsp [$];
	int          error_count = 0;
	int          burst_left = 0;
	int          stall_cycles = 0;

	compacting_array_table_top #(
		.DEPTH(DEPTH),
		.ELEMENT_WIDTH(32)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic cat_req_t mk_req(logic [2:0] action, logic [31:0] value,
			logic [7:0] first_index, logic [7:0] last_index);
		cat_req_t r;
		r.action = action;
		r.value = value;
		r.first_index = first_index;
		r.last_index = last_index;
		return r;
	endfunction

	// update the shadow table and return the response it implies
	function automatic cat_rsp_t apply_action(cat_req_t r);
		cat_rsp_t o;
		int span;
		o = '0;
		o.status = ST_OK;
		case (r.action)
			ACT_PUSH: begin
				if (shadow_fill >= DEPTH) begin
					o.status = ST_FULL;
				end else begin
					shadow_entries[shadow_fill] = r.value;
					shadow_fill++;
				end
			end
			ACT_FIND: begin
				o.status = ST_NOT_FOUND;
				for (int i = 0; i < shadow_fill; i++) begin
					if (shadow_entries[i] == r.value) begin
						o.status = ST_OK;
						o.found_index = i[7:0];
						break;
					end
				end
			end
			ACT_DELETE: begin
				if (r.first_index > r.last_index || int'(r.last_index) >= shadow_fill) begin
					o.status = ST_BAD_INDEX;
				end else begin
					span = int'(r.last_index) - int'(r.first_index) + 1;
					for (int i = int'(r.last_index) + 1; i < shadow_fill; i++)
						shadow_entries[i - span] = shadow_entries[i];
					shadow_fill -= span;
				end
			end
			ACT_CLEAR: begin
				shadow_fill = 0;
			end
			ACT_READ: begin
				if (int'(r.first_index) >= shadow_fill)
					o.status = ST_BAD_INDEX;
				else
					o.read_value = shadow_entries[r.first_index];
			end
			default: begin
			end
		endcase
		o.fill_count = shadow_fill[8:0];
		return o;
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] MISMATCH: %s", $time, msg);
		error_count++;
	endtask

	// hold start high until the transfer, then maybe drop it for a gap
	task automatic send_req(cat_req_t r);
		int gap;
		start <= 1'b1;
		req <= r;
		do @(posedge clk); while (busy !== 1'b0);
		pending_rsp.push_back(apply_action(r));
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
				: $urandom_range(0, 10);
			gap = $urandom_range(1, 6);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		cat_rsp_t exp_rsp;
		if (arst_n && done === 1'b1) begin
			if (pending_rsp.size() == 0) begin
				report_mismatch($sformatf("response with none expected: %p", rsp));
			end else begin
				exp_rsp = pending_rsp.pop_front();
				if (rsp.status !== exp_rsp.status)
					report_mismatch($sformatf("status got %0d exp %0d",
						rsp.status, exp_rsp.status));
				if (rsp.found_index !== exp_rsp.found_index)
					report_mismatch($sformatf("found_index got %0d exp %0d",
						rsp.found_index, exp_rsp.found_index));
				if (rsp.read_value !== exp_rsp.read_value)
					report_mismatch($sformatf("read_value got %h exp %h",
						rsp.read_value, exp_rsp.read_value));
				if (rsp.fill_count !== exp_rsp.fill_count)
					report_mismatch($sformatf("fill_count got %0d exp %0d",
						rsp.fill_count, exp_rsp.fill_count));
			end
		end
	end

	always @(posedge clk) begin
		if ((start && busy === 1'b0) || done === 1'b1)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_directed();
		send_req(mk_req(ACT_READ, '0, 8'd0, 8'd0));
		send_req(mk_req(ACT_DELETE, '0, 8'd0, 8'd0));
		send_req(mk_req(ACT_FIND, '0, 8'd0, 8'd0));
		send_req(mk_req(ACT_PUSH, 32'h0000_0000, 8'd0, 8'd0));
		send_req(mk_req(ACT_PUSH, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
		send_req(mk_req(ACT_PUSH, 32'hA5A5_A5A5, 8'd0, 8'd0));
		send_req(mk_req(ACT_PUSH, 32'h0000_0000, 8'd0, 8'd0));
		send_req(mk_req(ACT_PUSH, 32'h5A5A_5A5A, 8'd0, 8'd0));
		send_req(mk_req(ACT_FIND, 32'h0000_0000, 8'd0, 8'd0));
		send_req(mk_req(ACT_FIND, 32'hFFFF_FFFF, 8'd0, 8'd0));
		send_req(mk_req(ACT_FIND, 32'h5A5A_5A5A, 8'd0, 8'd0));
		send_req(mk_req(ACT_FIND, 32'h1234_5678, 8'd0, 8'd0));
		send_req(mk_req(ACT_READ, '0, 8'd0, 8'd0));
		send_req(mk_req(ACT_READ, '0, 8'd4, 8'd0));
		send_req(mk_req(ACT_READ, '0, 8'd5, 8'd0));
		send_req(mk_req(ACT_READ, '0, 8'hFF, 8'hFF));
		send_req(mk_req(ACT_DELETE, '0, 8'd3, 8'd1));
		send_req(mk_req(ACT_DELETE, '0, 8'd2, 8'd5));
		send_req(mk_req(ACT_DELETE, '0, 8'd1, 8'd2));
		send_req(mk_req(ACT_READ, '0, 8'd1, 8'd0));
		for (int k = 1; k <= 3; k++)
			send_req(mk_req(ACT_LAST + 3'(k), 32'hFFFF_FFFF, 8'hFF, 8'hFF));
		send_req(mk_req(ACT_DELETE, '0, 8'd0, 8'd2));
		send_req(mk_req(ACT_PUSH, 32'hDEAD_BEEF, 8'd0, 8'd0));
		send_req(mk_req(ACT_CLEAR, 32'hFFFF_FFFF, 8'hFF, 8'hFF));
		send_req(mk_req(ACT_READ, '0, 8'd0, 8'd0));
	endtask

	task automatic test_full_table();
		send_req(mk_req(ACT_CLEAR, '0, 8'd0, 8'd0));
		for (int i = 0; i < DEPTH; i++)
			send_req(mk_req(ACT_PUSH, $urandom, 8'($urandom), 8'($urandom)));
		send_req(mk_req(ACT_PUSH, $urandom, 8'd0, 8'd0));
		send_req(mk_req(ACT_FIND, shadow_entries[DEPTH - 1], 8'd0, 8'd0));
		send_req(mk_req(ACT_FIND, ~shadow_entries[DEPTH - 1], 8'd0, 8'd0));
		send_req(mk_req(ACT_READ, '0, 8'hFF, 8'd0));
		send_req(mk_req(ACT_DELETE, '0, 8'hFF, 8'hFF));
		send_req(mk_req(ACT_PUSH, 32'hFFFF_FFFF, 8'd0, 8'd0));
		send_req(mk_req(ACT_DELETE, '0, 8'd0, 8'd0));
		send_req(mk_req(ACT_PUSH, 32'h0000_0001, 8'd0, 8'd0));
		send_req(mk_req(ACT_DELETE, '0, 8'd0, 8'hFF));
		for (int i = 0; i < 40; i++)
			send_req(mk_req(ACT_PUSH, $urandom, 8'd0, 8'd0));
	endtask

	function automatic cat_req_t random_req();
		cat_req_t r;
		int pick;
		int lim;
		r.action = ACT_PUSH;
		r.value = $urandom;
		r.first_index = 8'($urandom);
		r.last_index = 8'($urandom);
		pick = $urandom_range(0, 99);
		if (pick < 35) begin
			r.action = ACT_PUSH;
			if ($urandom_range(0, 3) == 0)
				r.value = 32'($urandom_range(0, 7));
		end else if (pick < 55) begin
			r.action = ACT_FIND;
			if (shadow_fill > 0 && $urandom_range(0, 3) != 0)
				r.value = shadow_entries[$urandom_range(0, shadow_fill - 1)];
		end else if (pick < 72) begin
			r.action = ACT_DELETE;
			if (shadow_fill > 0 && $urandom_range(0, 4) != 0) begin
				r.first_index = 8'($urandom_range(0, shadow_fill - 1));
				lim = shadow_fill - 1 - int'(r.first_index);
				if ($urandom_range(0, 9) != 0 && lim > 3)
					lim = 3;
				r.last_index = r.first_index + 8'($urandom_range(0, lim));
			end
		end else if (pick < 75) begin
			r.action = ACT_CLEAR;
		end else if (pick < 95) begin
			r.action = ACT_READ;
			if (shadow_fill > 0 && $urandom_range(0, 4) != 0)
				r.first_index = 8'($urandom_range(0, shadow_fill - 1));
		end else begin
			r.action = ACT_LAST + 3'($urandom_range(1, 3));
		end
		return r;
	endfunction

	task automatic test_random_mix();
		for (int i = 0; i < RANDOM_ITEMS; i++)
			send_req(random_req());
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_full_table();
		test_random_mix();
		start <= 1'b0;
		while (pending_rsp.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
